>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_HOLDS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// consequent holds in the cycle after the trigger
`define ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> sv/wfwh_pkg.sv
package wfwh_pkg;

  localparam int unsigned NumBinsDef  = 2048;
  localparam int unsigned BinWidthDef = 20;

  localparam int unsigned LifetimeW = 16;
  localparam int unsigned WeightW   = 24;
  localparam int unsigned BinIdxW   = 11;
  localparam int unsigned SumW      = 32;
  localparam int unsigned BinWidthW = 11;
  localparam int unsigned RecipFrac = 16;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

endpackage

>>> sv/wfwh_ram.sv
module wfwh_ram #(
  parameter int unsigned Depth = wfwh_pkg::NumBinsDef,
  parameter int unsigned AddrW = $clog2(wfwh_pkg::NumBinsDef)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [wfwh_pkg::SumW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [wfwh_pkg::SumW-1:0] rdata_o
);

  logic [wfwh_pkg::SumW-1:0] mem_q [Depth];
  logic [wfwh_pkg::SumW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/wfwh_div.sv
`include "assert_macros.svh"

module wfwh_div #(
  parameter int unsigned BIN_WIDTH = wfwh_pkg::BinWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [wfwh_pkg::LifetimeW-1:0] x_i,
  output logic                           valid_o,
  output logic [wfwh_pkg::LifetimeW-1:0] quot_o
);

  localparam int unsigned RecipW = wfwh_pkg::RecipFrac + 1;
  localparam int unsigned ProdW  = wfwh_pkg::LifetimeW + RecipW;
  localparam int unsigned QwW    = wfwh_pkg::LifetimeW + wfwh_pkg::BinWidthW;
  localparam logic [RecipW-1:0] Recip =
    RecipW'((1 << wfwh_pkg::RecipFrac) / BIN_WIDTH);
  localparam logic [wfwh_pkg::BinWidthW-1:0] BinW = wfwh_pkg::BinWidthW'(BIN_WIDTH);

  logic                           v1_q, v2_q;
  logic [wfwh_pkg::LifetimeW-1:0] x1_q, x2_q;
  logic [ProdW-1:0]               prod_q;
  logic [wfwh_pkg::LifetimeW-1:0] q0, q0_q, qw_q, rem;
  logic [QwW-1:0]                 qw_full;

  assign q0      = prod_q[wfwh_pkg::RecipFrac +: wfwh_pkg::LifetimeW];
  assign qw_full = q0 * BinW;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q   <= x_i;
    prod_q <= ProdW'(x_i) * ProdW'(Recip);
    x2_q   <= x1_q;
    q0_q   <= q0;
    qw_q   <= qw_full[wfwh_pkg::LifetimeW-1:0];
  end

  // estimate is exact or one low
  assign rem     = x2_q - qw_q;
  assign quot_o  = ({1'b0, rem} >= 17'(BIN_WIDTH)) ? q0_q + 16'd1 : q0_q;
  assign valid_o = v2_q;

  `ASSERT_NEXT(a_div_stage, v1_q, v2_q)
  `ASSERT_HOLDS(a_div_exact, !valid_o || ((32'(x2_q) - 32'(quot_o) * 32'(BIN_WIDTH)) < 32'(BIN_WIDTH)))

endmodule

>>> sv/weighted_fixed_width_histogram_core.sv
// weighted histogram over fixed-width lifetime bins
// input channel: in_valid_i/in_ready_o with opcode, lifetime, weight, bin_index
//   opcode 0 adds weight to the bin holding lifetime (bin k spans
//   1+BIN_WIDTH*k .. BIN_WIDTH*(k+1)), sums saturate at 32 bits
//   opcode 1 reads back one bin's bounds and sum
// output channel: out_valid_o/out_ready_i, one beat per input beat, in order
// flow: a read passes ST_RD and ST_WR; an accumulate waits in ST_DIV for the
//   two-stage reciprocal divider first; a new item is taken only in ST_IDLE, after the
//   last one has left the read-modify-write of the sum memory
// reset: a clearing pass writes zero to all NUM_BINS entries, one per cycle,
//   so in_ready_o stays low until the pass is done
// stall: a finished beat waits in the output register; the next item may be
//   accepted meanwhile and holds in its write-back step until the register frees
`include "assert_macros.svh"

module weighted_fixed_width_histogram_core #(
  parameter int unsigned NUM_BINS  = wfwh_pkg::NumBinsDef,
  parameter int unsigned BIN_WIDTH = wfwh_pkg::BinWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           in_opcode_i,
  input  logic [wfwh_pkg::LifetimeW-1:0] in_lifetime_i,
  input  logic [wfwh_pkg::WeightW-1:0]   in_weight_i,
  input  logic [wfwh_pkg::BinIdxW-1:0]   in_bin_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           out_accepted_o,
  output logic [wfwh_pkg::BinIdxW-1:0]   out_bin_number_o,
  output logic [wfwh_pkg::LifetimeW-1:0] out_bin_low_o,
  output logic [wfwh_pkg::LifetimeW-1:0] out_bin_high_o,
  output logic [wfwh_pkg::SumW-1:0]      out_bin_sum_o
);

  localparam int unsigned AddrW = $clog2(NUM_BINS);
  localparam int unsigned BndW  = wfwh_pkg::LifetimeW + wfwh_pkg::BinWidthW;
  localparam logic [AddrW-1:0] LastBin = AddrW'(NUM_BINS - 1);
  localparam logic [wfwh_pkg::BinWidthW-1:0] BinW = wfwh_pkg::BinWidthW'(BIN_WIDTH);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_WR   = 3'd4;

  logic [2:0]                     state_q, state_d;
  logic [AddrW-1:0]               clr_q;
  logic                           op_q, zero_q, hit_q;
  logic [wfwh_pkg::WeightW-1:0]   weight_q;
  logic [wfwh_pkg::LifetimeW-1:0] bin_q;
  logic                           out_valid_q;
  logic                           acc_q;
  logic [wfwh_pkg::BinIdxW-1:0]   num_q;
  logic [wfwh_pkg::LifetimeW-1:0] low_q, high_q;
  logic [wfwh_pkg::SumW-1:0]      sum_q;

  logic                           in_fire, out_free, load;
  logic                           div_valid;
  logic [wfwh_pkg::LifetimeW-1:0] div_quot;
  logic                           in_range;
  logic                           ram_we, ram_re;
  logic [AddrW-1:0]               ram_waddr;
  logic [wfwh_pkg::SumW-1:0]      ram_wdata, ram_rdata, sum_new;
  logic [wfwh_pkg::SumW:0]        sum_ext;
  logic [BndW-1:0]                bnd_full;
  logic [wfwh_pkg::LifetimeW-1:0] bnd;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign load       = (state_q == ST_WR) && out_free;
  assign in_range   = {1'b0, bin_q} < 17'(NUM_BINS);

  wfwh_div #(
    .BIN_WIDTH(BIN_WIDTH)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_fire && (in_opcode_i == wfwh_pkg::OP_ACCUM)),
    .x_i    (in_lifetime_i - 16'd1),
    .valid_o(div_valid),
    .quot_o (div_quot)
  );

  assign sum_ext = {1'b0, ram_rdata} + 33'(weight_q);
  assign sum_new = (op_q == wfwh_pkg::OP_READ) ? ram_rdata :
                   (sum_ext[wfwh_pkg::SumW] ? '1 : sum_ext[wfwh_pkg::SumW-1:0]);

  assign ram_re    = (state_q == ST_RD);
  assign ram_we    = (state_q == ST_CLR) || (load && hit_q && (op_q == wfwh_pkg::OP_ACCUM));
  assign ram_waddr = (state_q == ST_CLR) ? clr_q : bin_q[AddrW-1:0];
  assign ram_wdata = (state_q == ST_CLR) ? '0 : sum_new;

  wfwh_ram #(
    .Depth(NUM_BINS),
    .AddrW(AddrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(bin_q[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign bnd_full = bin_q * BinW;
  assign bnd      = bnd_full[wfwh_pkg::LifetimeW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLR:  if (clr_q == LastBin) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_opcode_i == wfwh_pkg::OP_READ) ? ST_RD : ST_DIV;
        end
      end
      ST_DIV:  if (div_valid) state_d = ST_RD;
      ST_RD:   state_d = ST_WR;
      ST_WR:   if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= in_opcode_i;
      zero_q   <= (in_lifetime_i == '0);
      weight_q <= in_weight_i;
      bin_q    <= 16'(in_bin_index_i);
    end
    if ((state_q == ST_DIV) && div_valid) begin
      bin_q <= div_quot;
    end
    if (state_q == ST_RD) begin
      hit_q <= in_range && ((op_q == wfwh_pkg::OP_READ) || !zero_q);
    end
    if (load) begin
      acc_q  <= hit_q;
      num_q  <= (hit_q || (op_q == wfwh_pkg::OP_READ)) ? bin_q[wfwh_pkg::BinIdxW-1:0] : '0;
      low_q  <= hit_q ? bnd + 16'd1 : '0;
      high_q <= hit_q ? bnd + 16'(BinW) : '0;
      sum_q  <= hit_q ? sum_new : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_accepted_o   = acc_q;
  assign out_bin_number_o = num_q;
  assign out_bin_low_o    = low_q;
  assign out_bin_high_o   = high_q;
  assign out_bin_sum_o    = sum_q;

  `ASSERT_NEXT(a_accept_moves, in_fire, state_q == ST_RD || state_q == ST_DIV)
  `ASSERT_HOLDS(a_write_is_hit,
                !ram_we || state_q == ST_CLR || (hit_q && op_q == wfwh_pkg::OP_ACCUM))
  `ASSERT_HOLDS(a_bin_span, !(out_valid_o && out_accepted_o) ||
                16'(out_bin_high_o - out_bin_low_o) == 16'(BIN_WIDTH - 1))

endmodule
